// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, token kind codes and the keyword table of the C subset
// tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Default sizes of the position counters and the kept identifier prefix
  localparam int OFFSET_BITS_DEF   = 24;
  localparam int LINE_BITS_DEF     = 20;
  localparam int KEYWORD_CHARS_DEF = 6;

  // Result queue depth (power of two)
  localparam int FIFO_DEPTH = 4;

  // Token kinds
  localparam logic [5:0] KIND_EOF       = 6'd0;
  localparam logic [5:0] KIND_PLUS      = 6'd1;
  localparam logic [5:0] KIND_MINUS     = 6'd2;
  localparam logic [5:0] KIND_STAR      = 6'd3;
  localparam logic [5:0] KIND_SLASH     = 6'd4;
  localparam logic [5:0] KIND_AMP       = 6'd5;
  localparam logic [5:0] KIND_LPAREN    = 6'd6;
  localparam logic [5:0] KIND_RPAREN    = 6'd7;
  localparam logic [5:0] KIND_LBRACK    = 6'd8;
  localparam logic [5:0] KIND_RBRACK    = 6'd9;
  localparam logic [5:0] KIND_LBRACE    = 6'd10;
  localparam logic [5:0] KIND_RBRACE    = 6'd11;
  localparam logic [5:0] KIND_SEMI      = 6'd12;
  localparam logic [5:0] KIND_COMMA     = 6'd13;
  localparam logic [5:0] KIND_DOT       = 6'd14;
  localparam logic [5:0] KIND_ASSIGN    = 6'd15;
  localparam logic [5:0] KIND_EQUAL     = 6'd16;
  localparam logic [5:0] KIND_NOTEQUAL  = 6'd17;
  localparam logic [5:0] KIND_GREATER   = 6'd18;
  localparam logic [5:0] KIND_GREATEREQ = 6'd19;
  localparam logic [5:0] KIND_LESS      = 6'd20;
  localparam logic [5:0] KIND_LESSEQ    = 6'd21;
  localparam logic [5:0] KIND_NUMBER    = 6'd22;
  localparam logic [5:0] KIND_IDENT     = 6'd23;
  localparam logic [5:0] KIND_IF        = 6'd24;
  localparam logic [5:0] KIND_ELSE      = 6'd25;
  localparam logic [5:0] KIND_WHILE     = 6'd26;
  localparam logic [5:0] KIND_DO        = 6'd27;
  localparam logic [5:0] KIND_FOR       = 6'd28;
  localparam logic [5:0] KIND_RETURN    = 6'd29;
  localparam logic [5:0] KIND_CHAR      = 6'd30;
  localparam logic [5:0] KIND_SHORT     = 6'd31;
  localparam logic [5:0] KIND_INT       = 6'd32;
  localparam logic [5:0] KIND_LONG      = 6'd33;
  localparam logic [5:0] KIND_SIZEOF    = 6'd34;
  localparam logic [5:0] KIND_STRUCT    = 6'd35;
  localparam logic [5:0] KIND_UNION     = 6'd36;
  localparam logic [5:0] KIND_ERROR     = 6'd37;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
  localparam logic [1:0] ERR_BANG     = 2'd2;
  localparam logic [1:0] ERR_UNCLOSED = 2'd3;

  // Keyword table: text packed first char in the upper byte, right aligned
  localparam int KW_COUNT = 13;
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h6966,          // if
    64'h656c7365,      // else
    64'h7768696c65,    // while
    64'h646f,          // do
    64'h666f72,        // for
    64'h72657475726e,  // return
    64'h63686172,      // char
    64'h73686f7274,    // short
    64'h696e74,        // int
    64'h6c6f6e67,      // long
    64'h73697a656f66,  // sizeof
    64'h737472756374,  // struct
    64'h756e696f6e     // union
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{
    16'd2, 16'd4, 16'd5, 16'd2, 16'd3, 16'd6, 16'd4,
    16'd5, 16'd3, 16'd4, 16'd6, 16'd6, 16'd5
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    KIND_IF, KIND_ELSE, KIND_WHILE, KIND_DO, KIND_FOR, KIND_RETURN, KIND_CHAR,
    KIND_SHORT, KIND_INT, KIND_LONG, KIND_SIZEOF, KIND_STRUCT, KIND_UNION
  };

  // Scanner modes
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINECMT,
    MODE_BLOCK,
    MODE_BLOCKSTAR,
    MODE_EQ,
    MODE_BANG,
    MODE_GT,
    MODE_LT,
    MODE_NUM,
    MODE_WORD
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] number_value;
    logic [1:0]  error_code;
    logic [19:0] token_line;
    logic [15:0] token_column;
    logic [23:0] token_offset;
    logic [15:0] token_length;
    logic        last;
  } res_item_t;

  // Results made by one input item, in output order
  typedef struct packed {
    logic [1:0] n;
    res_item_t  r0;
    res_item_t  r1;
  } push_t;

  function automatic logic [5:0] kw_classify(logic [63:0] prefix, logic [15:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (KW_LEN[i] == len && KW_TEXT[i] == prefix) kind = KW_KIND[i];
    end
    return kind;
  endfunction

endpackage

// ===== hdl/cst_scan.sv =====
// ----------------------------------------------------------------------------
// cst_scan
// Scanner state and per-byte token logic. Each processed item updates the
// state and hands zero, one or two results to the queue.
// ----------------------------------------------------------------------------
module cst_scan #(
  parameter int OFFSET_BITS   = cst_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS     = cst_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  cst_pkg::in_item_t item_i,
  output cst_pkg::push_t    push_o
);
  import cst_pkg::*;

  localparam int PW = 8 * KEYWORD_CHARS;

  mode_e                  mode_q, mode_d;
  logic [31:0]            acc_q, acc_d;
  logic [PW-1:0]          prefix_q, prefix_d;
  logic [15:0]            wlen_q, wlen_d;
  logic [OFFSET_BITS-1:0] st_off_q, st_off_d;
  logic [LINE_BITS-1:0]   st_line_q, st_line_d;
  logic [15:0]            st_col_q, st_col_d;
  logic [OFFSET_BITS-1:0] bp_q, bp_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [OFFSET_BITS-1:0] col_q, col_d;   // bp - line start

  logic [7:0]  ch;
  logic        is_end;
  logic        is_digit, is_letter, is_space, is_nl;
  logic [5:0]  punct_kind;
  logic        pend_op;
  mode_e       pend_mode;
  logic        do_idle, do_flush, op2;
  logic        a_valid, b_valid;
  res_item_t   a_res, b_res;
  logic [15:0] wlen_inc;
  logic [31:0] col32, off32, line32, st_off32, st_line32;
  logic [15:0] col_sat;

  assign ch     = item_i.ch;
  assign is_end = item_i.is_end | (item_i.ch == 8'd0);

  assign is_digit  = ch inside {["0":"9"]};
  assign is_letter = (ch inside {["a":"z"], ["A":"Z"]}) || ch == "_";
  assign is_space  = ch inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  assign is_nl     = ch == 8'h0A;

  assign wlen_inc = (wlen_q == 16'hFFFF) ? wlen_q : wlen_q + 16'd1;

  assign col32     = 32'(col_q);
  assign col_sat   = (col32 > 32'h0000_FFFF) ? 16'hFFFF : col32[15:0];
  assign off32     = 32'(bp_q);
  assign line32    = 32'(line_q);
  assign st_off32  = 32'(st_off_q);
  assign st_line32 = 32'(st_line_q);

  always_comb begin
    punct_kind = KIND_EOF;
    pend_op    = 1'b0;
    pend_mode  = MODE_IDLE;
    case (ch)
      "+": punct_kind = KIND_PLUS;
      "-": punct_kind = KIND_MINUS;
      "*": punct_kind = KIND_STAR;
      "&": punct_kind = KIND_AMP;
      "(": punct_kind = KIND_LPAREN;
      ")": punct_kind = KIND_RPAREN;
      "[": punct_kind = KIND_LBRACK;
      "]": punct_kind = KIND_RBRACK;
      "{": punct_kind = KIND_LBRACE;
      "}": punct_kind = KIND_RBRACE;
      ";": punct_kind = KIND_SEMI;
      ",": punct_kind = KIND_COMMA;
      ".": punct_kind = KIND_DOT;
      "/": begin pend_op = 1'b1; pend_mode = MODE_SLASH; end
      "=": begin pend_op = 1'b1; pend_mode = MODE_EQ;    end
      "!": begin pend_op = 1'b1; pend_mode = MODE_BANG;  end
      ">": begin pend_op = 1'b1; pend_mode = MODE_GT;    end
      "<": begin pend_op = 1'b1; pend_mode = MODE_LT;    end
      default: ;
    endcase
  end

  // What this byte does: flush the pending token, scan afresh, or finish a
  // two-char operator
  always_comb begin
    do_idle  = 1'b0;
    do_flush = 1'b0;
    op2      = 1'b0;
    if (is_end) begin
      do_flush = 1'b1;
    end else begin
      case (mode_q)
        MODE_SLASH: begin
          if (ch != "/" && ch != "*") begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_LINECMT: do_idle = is_nl;
        MODE_BLOCK, MODE_BLOCKSTAR: ;
        MODE_EQ, MODE_BANG, MODE_GT, MODE_LT: begin
          if (ch == "=") begin
            op2 = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_NUM: begin
          if (!is_digit) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_WORD: begin
          if (!(is_digit || is_letter)) begin
            do_flush = 1'b1;
            do_idle  = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end
  end

  // Next state
  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    prefix_d  = prefix_q;
    wlen_d    = wlen_q;
    st_off_d  = st_off_q;
    st_line_d = st_line_q;
    st_col_d  = st_col_q;
    bp_d      = bp_q;
    line_d    = line_q;
    col_d     = col_q;
    if (go_i) begin
      if (is_end) begin
        mode_d    = MODE_IDLE;
        acc_d     = '0;
        prefix_d  = '0;
        wlen_d    = '0;
        st_off_d  = '0;
        st_line_d = LINE_BITS'(1);
        st_col_d  = '0;
        bp_d      = '0;
        line_d    = LINE_BITS'(1);
        col_d     = '0;
      end else begin
        bp_d = bp_q + OFFSET_BITS'(1);
        if ((do_idle || mode_q == MODE_BLOCK || mode_q == MODE_BLOCKSTAR) && is_nl) begin
          line_d = line_q + LINE_BITS'(1);
          col_d  = '0;
        end else begin
          col_d = col_q + OFFSET_BITS'(1);
        end
        if (do_idle) begin
          mode_d = MODE_IDLE;
          if (!is_space) begin
            st_off_d  = bp_q;
            st_line_d = line_q;
            st_col_d  = col_sat;
            if (pend_op) begin
              mode_d = pend_mode;
            end else if (is_digit) begin
              acc_d  = {24'd0, ch - 8'h30};
              wlen_d = 16'd1;
              mode_d = MODE_NUM;
            end else if (is_letter) begin
              prefix_d = PW'(ch);
              wlen_d   = 16'd1;
              mode_d   = MODE_WORD;
            end
          end
        end else begin
          case (mode_q)
            MODE_SLASH: begin
              if (ch == "/") begin
                mode_d = MODE_LINECMT;
              end else begin
                mode_d = MODE_BLOCK;
                wlen_d = 16'd2;
              end
            end
            MODE_BLOCK, MODE_BLOCKSTAR: begin
              wlen_d = wlen_inc;
              if (mode_q == MODE_BLOCKSTAR && ch == "/") mode_d = MODE_IDLE;
              else if (ch == "*") mode_d = MODE_BLOCKSTAR;
              else mode_d = MODE_BLOCK;
            end
            MODE_EQ, MODE_BANG, MODE_GT, MODE_LT: mode_d = MODE_IDLE;
            MODE_NUM: begin
              acc_d  = (acc_q << 3) + (acc_q << 1) + {24'd0, ch - 8'h30};
              wlen_d = wlen_inc;
            end
            MODE_WORD: begin
              if (wlen_q < 16'(KEYWORD_CHARS)) prefix_d = {prefix_q[PW-9:0], ch};
              wlen_d = wlen_inc;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Results: a from the pending token (old start), b at the current byte
  always_comb begin
    a_res              = '0;
    a_res.token_line   = st_line32[19:0];
    a_res.token_column = st_col_q;
    a_res.token_offset = st_off32[23:0];
    a_res.token_length = 16'd1;
    a_valid            = 1'b0;
    if (op2) begin
      a_valid            = 1'b1;
      a_res.token_length = 16'd2;
      case (mode_q)
        MODE_EQ:   a_res.kind = KIND_EQUAL;
        MODE_BANG: a_res.kind = KIND_NOTEQUAL;
        MODE_GT:   a_res.kind = KIND_GREATEREQ;
        default:   a_res.kind = KIND_LESSEQ;
      endcase
    end else if (do_flush) begin
      a_valid = 1'b1;
      case (mode_q)
        MODE_SLASH: a_res.kind = KIND_SLASH;
        MODE_EQ:    a_res.kind = KIND_ASSIGN;
        MODE_BANG: begin
          a_res.kind       = KIND_ERROR;
          a_res.error_code = ERR_BANG;
        end
        MODE_GT:    a_res.kind = KIND_GREATER;
        MODE_LT:    a_res.kind = KIND_LESS;
        MODE_NUM: begin
          a_res.kind         = KIND_NUMBER;
          a_res.number_value = acc_q;
          a_res.token_length = wlen_q;
        end
        MODE_WORD: begin
          a_res.kind = (wlen_q > 16'(KEYWORD_CHARS)) ? KIND_IDENT
                     : kw_classify(64'(prefix_q), wlen_q);
          a_res.token_length = wlen_q;
        end
        MODE_BLOCK, MODE_BLOCKSTAR: begin
          // only reached at end of input
          a_res.kind         = KIND_ERROR;
          a_res.error_code   = ERR_UNCLOSED;
          a_res.token_length = wlen_q;
        end
        default: a_valid = 1'b0;
      endcase
    end

    b_res              = '0;
    b_res.token_line   = line32[19:0];
    b_res.token_column = col_sat;
    b_res.token_offset = off32[23:0];
    b_valid            = 1'b0;
    if (is_end) begin
      b_valid    = 1'b1;
      b_res.kind = KIND_EOF;
    end else if (do_idle && !is_space && !pend_op && !is_digit && !is_letter) begin
      b_valid            = 1'b1;
      b_res.token_length = 16'd1;
      if (punct_kind != KIND_EOF) begin
        b_res.kind = punct_kind;
      end else begin
        b_res.kind       = KIND_ERROR;
        b_res.error_code = ERR_ILLEGAL;
      end
    end

    push_o    = '0;
    push_o.r1 = b_res;
    push_o.r0 = a_valid ? a_res : b_res;
    if (go_i) begin
      push_o.n = 2'(a_valid) + 2'(b_valid);
    end
    if (push_o.n == 2'd2) push_o.r1.last = 1'b1;
    else push_o.r0.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      acc_q     <= '0;
      prefix_q  <= '0;
      wlen_q    <= '0;
      st_off_q  <= '0;
      st_line_q <= LINE_BITS'(1);
      st_col_q  <= '0;
      bp_q      <= '0;
      line_q    <= LINE_BITS'(1);
      col_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      acc_q     <= acc_d;
      prefix_q  <= prefix_d;
      wlen_q    <= wlen_d;
      st_off_q  <= st_off_d;
      st_line_q <= st_line_d;
      st_col_q  <= st_col_d;
      bp_q      <= bp_d;
      line_q    <= line_d;
      col_q     <= col_d;
    end
  end

endmodule

// ===== hdl/cst_res_fifo.sv =====
// ----------------------------------------------------------------------------
// cst_res_fifo
// Result queue. Takes up to two results per cycle from the scanner and
// delivers one per cycle on the output channel while the output is not stalled.
// ----------------------------------------------------------------------------
module cst_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::push_t     push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cst_pkg::res_item_t out_data_o
);
  import cst_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  res_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for a worst-case item of two results
  assign room_o      = cnt_q <= CNT_W'(FIFO_DEPTH - 2);

  assign wr_d  = wr_q + PTR_W'(push_i.n);
  assign rd_d  = rd_q + PTR_W'(pop);
  assign cnt_d = cnt_q + CNT_W'(push_i.n) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_q + PTR_W'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/c_subset_tokenizer.sv =====
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming tokenizer for a small C subset, one source byte per item.
// ----------------------------------------------------------------------------
// One source byte is accepted per clock while in_stall_o is low. A taken
// byte is held in the input register and scanned from it, against the
// scanner state, once the queue has room; it writes zero, one or two tokens
// into a four-entry result queue, from which its first token is offered.
// The queue drains one token per cycle while the output is not stalled, so a
// byte that closes a pending token and starts a one-byte token yields two
// tokens to drain, and input stalls while the queue holds more than two
// tokens. An end flag or a zero byte flushes the pending token, emits
// end-of-file and returns the scanner to line 1, offset 0.
module c_subset_tokenizer #(
  parameter int OFFSET_BITS   = cst_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS     = cst_pkg::LINE_BITS_DEF,
  parameter int KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cst_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cst_pkg::res_item_t out_data_o
);
  import cst_pkg::*;

  logic     in_vld_q;
  in_item_t in_q;
  logic     room;
  logic     go;
  push_t    push;

  assign go         = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
  end

  cst_scan #(
    .OFFSET_BITS  (OFFSET_BITS),
    .LINE_BITS    (LINE_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (go),
    .item_i(in_q),
    .push_o(push)
  );

  cst_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
